>>> rtl/core/assert_macros.svh
// assertion macros used by the rgbc top-level rtl file
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RGBC_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbc assertion failed");

// next-cycle implication
`define RGBC_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbc assertion failed");

`endif

>>> rtl/core/rgbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_pkg
// types and constants of the 3x3 rgb convolution block
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = COL_W + 2;
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int CMP_W     = ((COL_W > WID_W) ? COL_W : WID_W) + 1;
    localparam int PROD_W    = 17;
    localparam int SUM_W     = 20;
    localparam int SCL_W     = 16;
    localparam int MUL_W     = SUM_W - 1 + SCL_W;
    localparam int FRAC_W    = 12;
    localparam int TAPS      = 9;

    // register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAX    = 3'd2;
    localparam logic [2:0] REG_KTOP   = 3'd3;
    localparam logic [2:0] REG_KMID   = 3'd4;
    localparam logic [2:0] REG_KBOT   = 3'd5;
    localparam logic [2:0] REG_SCALE  = 3'd6;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_done;
    } pix_out_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] red;
        logic signed [PROD_W-1:0] green;
        logic signed [PROD_W-1:0] blue;
    } prod3_t;

    typedef struct packed {
        logic sum_en;
        logic mul_en;
    } post_ctrl_t;

endpackage

>>> rtl/core/rgbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_cell
// one window tap: holds a pixel, passes it on, forms its weighted product
// ----------------------------------------------------------------------------
module rgbc_cell
(
    input  logic                  clk,
    input  logic                  shift,
    input  logic [23:0]           pix_in,
    input  logic signed [7:0]     coef,
    output logic [23:0]           pix_out,
    output rgbc_pkg::prod3_t      prod
);
    import rgbc_pkg::*;

    logic [23:0] pix_reg;
    prod3_t      prod_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            pix_reg <= pix_in;
        end
        prod_reg.red   <= PROD_W'($signed({1'b0, pix_reg[23:16]})) * PROD_W'(coef);
        prod_reg.green <= PROD_W'($signed({1'b0, pix_reg[15:8]})) * PROD_W'(coef);
        prod_reg.blue  <= PROD_W'($signed({1'b0, pix_reg[7:0]})) * PROD_W'(coef);
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule

>>> rtl/core/rgbc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_post
// sums the tap products, scales by the q4.12 factor and clamps
// ----------------------------------------------------------------------------
module rgbc_post
(
    input  logic                     clk,
    input  rgbc_pkg::post_ctrl_t     ctrl,
    input  rgbc_pkg::prod3_t         prods [rgbc_pkg::TAPS],
    input  logic [rgbc_pkg::SCL_W-1:0] scale,
    input  logic [7:0]               max_level,
    output logic [23:0]              rgb
);
    import rgbc_pkg::*;

    logic signed [SUM_W-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic signed [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [MUL_W-1:0]        mul_r_reg, mul_g_reg, mul_b_reg;

    always_comb
    begin
        sum_r_next = '0;
        sum_g_next = '0;
        sum_b_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            sum_r_next = sum_r_next + SUM_W'(prods[i].red);
            sum_g_next = sum_g_next + SUM_W'(prods[i].green);
            sum_b_next = sum_b_next + SUM_W'(prods[i].blue);
        end
    end

    function automatic logic [SUM_W-2:0] pos_part(input logic signed [SUM_W-1:0] s);
        pos_part = (s > 0) ? s[SUM_W-2:0] : '0;
    endfunction

    function automatic logic [7:0] clamp(input logic [MUL_W-1:0] m, input logic [7:0] mx);
        logic [MUL_W-FRAC_W-1:0] v;
        v = m[MUL_W-1:FRAC_W];
        clamp = (v > (MUL_W-FRAC_W)'(mx)) ? mx : v[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
        if (ctrl.mul_en)
        begin
            mul_r_reg <= MUL_W'(pos_part(sum_r_reg)) * MUL_W'(scale);
            mul_g_reg <= MUL_W'(pos_part(sum_g_reg)) * MUL_W'(scale);
            mul_b_reg <= MUL_W'(pos_part(sum_b_reg)) * MUL_W'(scale);
        end
    end

    assign rgb = {clamp(mul_r_reg, max_level), clamp(mul_g_reg, max_level),
                  clamp(mul_b_reg, max_level)};

endmodule

>>> rtl/core/rgb_convolution_3x3_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_clamped
// streaming 3x3 rgb convolution with edge replication, scale and clamp
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  pix       | pix_valid / pix_ready | pix_data  (opcode, red/green/blue_in)
//  res       | res_valid / res_ready | res_data  (red/green/blue_out, frame_done)
//  config    | apb psel/penable      | paddr[4:2] register index, pwdata
//
//  an item that gives no result leaves pix_ready high; one that gives a result
//  holds pix_ready low through the nine single-port reads of the row memory that load
//  the tap chain, then product, sum, scale and clamp stages
//  the row memory holds four rows and needs no clearing after reset
//  a finished result waits in the output register; the next item is taken
//  meanwhile and stalls only in its last stage if that register is still full
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_clamped
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  rgbc_pkg::pix_in_t   pix_data,
    output logic                res_valid,
    input  logic                res_ready,
    output rgbc_pkg::pix_out_t  res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rgbc_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_PROD = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // configuration registers
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [7:0]       max_reg;
    logic [23:0]      ktop_reg, kmid_reg, kbot_reg;
    logic [SCL_W-1:0] scale_reg;

    // frame position
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [HGT_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [HGT_W-1:0] out_row_reg, out_row_next;

    // emission context, captured when the item is accepted
    logic [1:0]       up_reg, mid_reg, dn_reg;
    logic [COL_W-1:0] lf_reg, ct_reg, rt_reg;
    logic             last_reg, last_next;
    logic [1:0]       up_next, mid_next, dn_next;
    logic [COL_W-1:0] lf_next, ct_next, rt_next;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       dy_reg, dy_next, dx_reg, dx_next;
    logic             rd_vld_reg;

    logic             res_valid_reg;
    pix_out_t         res_reg;

    logic [23:0]      mem [2**ADDR_W];
    logic [23:0]      mem_q_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic             mem_we;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic             accept, full, emit, cfg_wr;
    logic [2:0]       cfg_idx;

    // tap chain and post stage signals
    logic [2:0][23:0] krows;
    logic [23:0]      chain [TAPS+1];
    prod3_t           prods [TAPS];
    logic [23:0]      rgb;
    post_ctrl_t       pctrl;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // effective geometry: zero acts as one, width above the store is capped
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? HGT_W'(1) : height_reg;
    end

    assign pix_ready = (state_reg == S_IDLE);
    assign accept    = pix_valid & pix_ready;
    assign full      = (in_row_reg >= h_eff);
    assign mem_we    = accept & (pix_data.opcode == OP_PIXEL) & ~full;

    // next-state and counter logic
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        state_next   = state_reg;
        dy_next      = dy_reg;
        dx_next      = dx_reg;
        emit         = 1'b0;

        // neighbor rows and columns of the output position, edges replicated
        up_next  = (out_row_reg == '0) ? out_row_reg[1:0] : out_row_reg[1:0] - 2'd1;
        mid_next = out_row_reg[1:0];
        dn_next  = ((17'(out_row_reg) + 17'd1) >= 17'(h_eff)) ? out_row_reg[1:0]
                                                             : out_row_reg[1:0] + 2'd1;
        lf_next  = (out_col_reg == '0) ? out_col_reg : out_col_reg - COL_W'(1);
        ct_next  = out_col_reg;
        rt_next  = ((CMP_W'(out_col_reg) + CMP_W'(1)) >= CMP_W'(w_eff)) ? out_col_reg
                                                                          : out_col_reg + COL_W'(1);
        last_next = (out_row_reg == h_eff - HGT_W'(1)) &&
                    (CMP_W'(out_col_reg) == CMP_W'(w_eff) - CMP_W'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (pix_data.opcode == OP_PIXEL)
                    begin
                        if (!full)
                        begin
                            // at least one row plus one pixel already received
                            emit = (in_row_reg >= HGT_W'(2)) ||
                                   ((in_row_reg == HGT_W'(1)) && (in_col_reg != '0));
                            if ((CMP_W'(in_col_reg) + CMP_W'(1)) >= CMP_W'(w_eff))
                            begin
                                in_col_next = '0;
                                in_row_next = in_row_reg + HGT_W'(1);
                            end
                            else
                            begin
                                in_col_next = in_col_reg + COL_W'(1);
                            end
                        end
                    end
                    else if (full)
                    begin
                        if (out_row_reg >= h_eff)
                        begin
                            in_col_next  = '0;
                            in_row_next  = '0;
                            out_col_next = '0;
                            out_row_next = '0;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    if (emit)
                    begin
                        state_next = S_READ;
                        if (last_next)
                        begin
                            // end of frame: everything restarts
                            in_col_next  = '0;
                            in_row_next  = '0;
                            out_col_next = '0;
                            out_row_next = '0;
                        end
                        else if ((CMP_W'(out_col_reg) + CMP_W'(1)) >= CMP_W'(w_eff))
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + HGT_W'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + COL_W'(1);
                        end
                    end
                end
            end
            S_READ:
            begin
                if (dx_reg == 2'd2)
                begin
                    dx_next = 2'd0;
                    if (dy_reg == 2'd2)
                    begin
                        dy_next    = 2'd0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        dy_next = dy_reg + 2'd1;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 2'd1;
                end
            end
            S_FILL: state_next = S_PROD;
            S_PROD: state_next = S_SUM;
            S_SUM:  state_next = S_MUL;
            S_MUL:  state_next = S_OUT;
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // geometry writes restart the frame
        if (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    // tap read address: rows up/mid/down, columns left/center/right
    always_comb
    begin
        logic [1:0]       r_sel;
        logic [COL_W-1:0] c_sel;
        case (dy_reg)
            2'd0:    r_sel = up_reg;
            2'd1:    r_sel = mid_reg;
            default: r_sel = dn_reg;
        endcase
        case (dx_reg)
            2'd0:    c_sel = lf_reg;
            2'd1:    c_sel = ct_reg;
            default: c_sel = rt_reg;
        endcase
        rd_addr = {r_sel, c_sel};
    end

    // four-row pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[{in_row_reg[1:0], in_col_reg}] <= {pix_data.red_in, pix_data.green_in,
                                                   pix_data.blue_in};
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WID_W'(1024);
            height_reg    <= HGT_W'(1);
            max_reg       <= 8'd255;
            ktop_reg      <= 24'd0;
            kmid_reg      <= 24'd256;
            kbot_reg      <= 24'd0;
            scale_reg     <= SCL_W'(4096);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            state_reg     <= S_IDLE;
            dy_reg        <= '0;
            dx_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_WIDTH:  width_reg  <= pwdata[WID_W-1:0];
                    REG_HEIGHT: height_reg <= pwdata[HGT_W-1:0];
                    REG_MAX:    max_reg    <= pwdata[7:0];
                    REG_KTOP:   ktop_reg   <= pwdata[23:0];
                    REG_KMID:   kmid_reg   <= pwdata[23:0];
                    REG_KBOT:   kbot_reg   <= pwdata[23:0];
                    REG_SCALE:  scale_reg  <= pwdata[SCL_W-1:0];
                    default:    ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            state_reg   <= state_next;
            dy_reg      <= dy_next;
            dx_reg      <= dx_next;
            rd_vld_reg  <= (state_reg == S_READ);
            if (state_reg == S_OUT && (!res_valid_reg || res_ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // emission context and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg   <= up_next;
            mid_reg  <= mid_next;
            dn_reg   <= dn_next;
            lf_reg   <= lf_next;
            ct_reg   <= ct_next;
            rt_reg   <= rt_next;
            last_reg <= last_next;
        end
        if (state_reg == S_OUT && (!res_valid_reg || res_ready))
        begin
            {res_reg.red_out, res_reg.green_out, res_reg.blue_out} <= rgb;
            res_reg.frame_done <= last_reg;
        end
    end

    // register read-back
    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_MAX:    prdata = 32'(max_reg);
            REG_KTOP:   prdata = 32'(ktop_reg);
            REG_KMID:   prdata = 32'(kmid_reg);
            REG_KBOT:   prdata = 32'(kbot_reg);
            REG_SCALE:  prdata = 32'(scale_reg);
            default:    prdata = '0;
        endcase
    end

    // tap chain: cell i ends up holding tap 8-i of the row-major read order
    assign krows    = {kbot_reg, kmid_reg, ktop_reg};
    assign chain[0] = mem_q_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TAPS; gi++)
        begin : g_cell
            localparam int T = TAPS - 1 - gi;
            rgbc_cell u_cell
            (
                .clk     (clk),
                .shift   (rd_vld_reg),
                .pix_in  (chain[gi]),
                .coef    ($signed(krows[T/3][8*(T%3) +: 8])),
                .pix_out (chain[gi+1]),
                .prod    (prods[gi])
            );
        end
    endgenerate

    assign pctrl.sum_en = (state_reg == S_SUM);
    assign pctrl.mul_en = (state_reg == S_MUL);

    rgbc_post u_post
    (
        .clk       (clk),
        .ctrl      (pctrl),
        .prods     (prods),
        .scale     (scale_reg),
        .max_level (max_reg),
        .rgb       (rgb)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // a waiting result is never overwritten
    `RGBC_AST_NEXT(a_out_hold, (state_reg == S_OUT) && res_valid_reg && !res_ready,
                   state_reg == S_OUT)
    // the ninth read is followed by the cycle that lands it in the chain
    `RGBC_AST_NEXT(a_read_end, (state_reg == S_READ) && (dy_reg == 2'd2) && (dx_reg == 2'd2),
                   (state_reg == S_FILL) && rd_vld_reg)
    // tap counters rest at zero outside the read phase
    `RGBC_AST_NOW(a_idle_cnt, state_reg != S_READ, (dy_reg == 2'd0) && (dx_reg == 2'd0))

endmodule
